>>> hw/rtl/urc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging controller package
// Shared widths, register indexes, reset values, the result record and the
// seven-segment decoder.
// ----------------------------------------------------------------------------
package urc_pkg;

  // Field and register widths.
  localparam int TRIG_W      = 10;
  localparam int HOLD_W      = 20;
  localparam int TICK_W      = 20;
  localparam int DIST_W      = 14;
  localparam int SEG_W       = 7;
  localparam int NUM_SEG     = 4;
  localparam int BCD_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 20;

  // Defaults for the top-level parameters.
  localparam int COUNT_BITS_DEF = 16;
  localparam int NUM_DIGITS_DEF = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 1'd1;

  // Register reset values.
  localparam logic [TRIG_W-1:0] TRIG_RESET = 10'd100;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 20'd100000;

  // Distance = floor(count * 1000 / 5882), tracked as a running quotient
  // and remainder while the echo is counted.
  localparam int                REM_W     = 13;
  localparam logic [REM_W-1:0]  DIST_STEP = 13'd1000;
  localparam logic [REM_W-1:0]  DIST_DIV  = 13'd5882;
  localparam logic [DIST_W-1:0] DIST_CAP  = 14'd9999;

  localparam logic [BCD_W-1:0]  BCD_NINE  = 4'd9;

  typedef logic [NUM_SEG-1:0][BCD_W-1:0] bcd_t;
  typedef logic [NUM_SEG-1:0][SEG_W-1:0] seg_t;

  typedef struct packed {
    logic              trigger_out;
    logic              done_res;
    logic [DIST_W-1:0] distance_cm;
    seg_t              seg;
  } res_t;

  // Segment a is bit 0, segment g is bit 6.
  function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

>>> hw/rtl/ultrasonic_ranging_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging controller
// Trigger/echo sequencer for a pulse-echo range sensor with distance output.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one 10 us tick carrying the sampled
// echo pin level. Each accepted tick produces exactly one result transfer:
// the trigger pin level for that tick, a done flag on the tick the echo falls,
// the last distance in centimeters and four seven-segment patterns of it.
// The configuration port sets the trigger length and the holdoff time; the
// user must write it only while the block is idle; the block does not check.
//
// An accepted tick's result is registered at its edge in the output or skid
// register. Throughput is one tick per cycle while in_stall is low. The
// distance is never divided at the end of a measurement: a quotient and a
// remainder of count * 1000 / 5882 advance with the echo counter, so the done
// tick only copies them, and a BCD copy of the quotient feeds the display.
//
// A two-entry output buffer (result register plus skid register) separates
// the channels. in_stall rises only once both entries hold results, so one
// more tick is taken while a result waits on a stalled receiver.
// Reset (rst_n low at a clock edge) empties the buffer, restores the register
// defaults, starts in the trigger phase and clears the stored distance.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_controller #(
  parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF,
  parameter int NUM_DIGITS = urc_pkg::NUM_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_echo_level,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_trigger_out,
  output logic                            out_done_res,
  output logic [urc_pkg::DIST_W-1:0]      out_distance_cm,
  output logic [urc_pkg::SEG_W-1:0]       out_seg_units,
  output logic [urc_pkg::SEG_W-1:0]       out_seg_tens,
  output logic [urc_pkg::SEG_W-1:0]       out_seg_hundreds,
  output logic [urc_pkg::SEG_W-1:0]       out_seg_thousands
);

  localparam logic [1:0] PH_TRIGGER = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_COUNT   = 2'd2;
  localparam logic [1:0] PH_HOLD    = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  // Configuration registers.
  logic [urc_pkg::TRIG_W-1:0]  trigger_ticks_r;
  logic [urc_pkg::HOLD_W-1:0]  holdoff_ticks_r;

  // Sequencer state.
  logic [1:0]                  phase_r,      phase_nxt;
  logic [urc_pkg::TICK_W-1:0]  tick_count_r, tick_count_nxt;
  logic [COUNT_BITS-1:0]       echo_count_r, echo_count_nxt;

  // Running quotient and remainder of echo_count * 1000 / 5882.
  logic [urc_pkg::DIST_W-1:0]  quot_r,       quot_nxt;
  logic [urc_pkg::REM_W-1:0]   rem_r,        rem_nxt;
  urc_pkg::bcd_t               quot_bcd_r,   quot_bcd_nxt;

  // Last finished measurement.
  logic [urc_pkg::DIST_W-1:0]  last_dist_r,  last_dist_nxt;
  urc_pkg::bcd_t               last_bcd_r,   last_bcd_nxt;

  // Output buffer.
  logic                        out_valid_r;
  urc_pkg::res_t               out_res_r;
  logic                        skid_valid_r;
  urc_pkg::res_t               skid_res_r;

  logic                        in_xfer;
  logic                        out_xfer;
  logic [urc_pkg::TICK_W-1:0]  tick_inc;
  logic [urc_pkg::REM_W-1:0]   rem_sum;
  urc_pkg::bcd_t               bcd_inc;
  logic                        bcd_carry;
  logic                        trig_now;
  logic                        done_now;
  urc_pkg::res_t               res_new;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;

  assign tick_inc = tick_count_r + urc_pkg::TICK_W'(1);
  assign rem_sum  = rem_r + urc_pkg::DIST_STEP;

  // BCD increment of the running quotient.
  always_comb begin
    bcd_carry = 1'b1;
    bcd_inc   = quot_bcd_r;
    for (int k = 0; k < urc_pkg::NUM_SEG; k++) begin
      if (bcd_carry) begin
        if (quot_bcd_r[k] == urc_pkg::BCD_NINE) begin
          bcd_inc[k] = '0;
        end else begin
          bcd_inc[k] = quot_bcd_r[k] + urc_pkg::BCD_W'(1);
          bcd_carry  = 1'b0;
        end
      end
    end
  end

  // Phase sequencer.
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    echo_count_nxt = echo_count_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    quot_bcd_nxt   = quot_bcd_r;
    last_dist_nxt  = last_dist_r;
    last_bcd_nxt   = last_bcd_r;
    trig_now       = 1'b0;
    done_now       = 1'b0;

    unique case (phase_r)
      PH_TRIGGER: begin
        trig_now       = 1'b1;
        tick_count_nxt = tick_inc;
        // A trigger length of zero still gives a one-tick pulse.
        if (tick_inc >= urc_pkg::TICK_W'(trigger_ticks_r)) begin
          tick_count_nxt = '0;
          phase_nxt      = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // The first high tick already counts as one.
        if (in_echo_level) begin
          echo_count_nxt = COUNT_ONE;
          quot_nxt       = '0;
          quot_bcd_nxt   = '0;
          rem_nxt        = urc_pkg::DIST_STEP;
          phase_nxt      = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (in_echo_level) begin
          if (echo_count_r != COUNT_MAX) begin
            echo_count_nxt = echo_count_r + COUNT_ONE;
            if (rem_sum >= urc_pkg::DIST_DIV) begin
              rem_nxt = rem_sum - urc_pkg::DIST_DIV;
              // The quotient freezes at the cap; the remainder no longer matters.
              if (quot_r != urc_pkg::DIST_CAP) begin
                quot_nxt     = quot_r + urc_pkg::DIST_W'(1);
                quot_bcd_nxt = bcd_inc;
              end
            end else begin
              rem_nxt = rem_sum;
            end
          end
        end else begin
          last_dist_nxt  = quot_r;
          last_bcd_nxt   = quot_bcd_r;
          done_now       = 1'b1;
          tick_count_nxt = '0;
          phase_nxt      = (holdoff_ticks_r == '0) ? PH_TRIGGER : PH_HOLD;
        end
      end
      PH_HOLD: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= holdoff_ticks_r) begin
          tick_count_nxt = '0;
          phase_nxt      = PH_TRIGGER;
        end
      end
      default: begin
        phase_nxt = PH_TRIGGER;
      end
    endcase
  end

  // Result record; digits beyond NUM_DIGITS read as blank.
  always_comb begin
    res_new.trigger_out = trig_now;
    res_new.done_res    = done_now;
    res_new.distance_cm = last_dist_nxt;
    for (int k = 0; k < urc_pkg::NUM_SEG; k++) begin
      if (k < NUM_DIGITS) begin
        res_new.seg[k] = urc_pkg::seg_decode(last_bcd_nxt[k]);
      end else begin
        res_new.seg[k] = '0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= urc_pkg::TRIG_RESET;
      holdoff_ticks_r <= urc_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urc_pkg::CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_data[urc_pkg::TRIG_W-1:0];
        urc_pkg::CFG_HOLDOFF_TICKS: holdoff_ticks_r <= cfg_data[urc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TRIGGER;
      tick_count_r <= '0;
      echo_count_r <= '0;
      quot_r       <= '0;
      rem_r        <= '0;
      quot_bcd_r   <= '0;
      last_dist_r  <= '0;
      last_bcd_r   <= '0;
    end else if (in_xfer) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      echo_count_r <= echo_count_nxt;
      quot_r       <= quot_nxt;
      rem_r        <= rem_nxt;
      quot_bcd_r   <= quot_bcd_nxt;
      last_dist_r  <= last_dist_nxt;
      last_bcd_r   <= last_bcd_nxt;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (out_valid_r && !out_xfer) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_xfer) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (out_valid_r && !out_xfer) begin
        skid_res_r <= res_new;
      end else begin
        out_res_r <= res_new;
      end
    end else if (out_xfer && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_out   = out_res_r.trigger_out;
  assign out_done_res      = out_res_r.done_res;
  assign out_distance_cm   = out_res_r.distance_cm;
  assign out_seg_units     = out_res_r.seg[0];
  assign out_seg_tens      = out_res_r.seg[1];
  assign out_seg_hundreds  = out_res_r.seg[2];
  assign out_seg_thousands = out_res_r.seg[3];

endmodule
